// ===== design/collision_impulse_resolver_unit_defines.svh =====
// Assertion macros shared by the collision impulse resolver design files.
`ifndef COLLISION_IMPULSE_RESOLVER_UNIT_DEFINES_SVH
`define COLLISION_IMPULSE_RESOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Condition checked in the same cycle as the trigger.
`define CIR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("collision impulse resolver check failed");
// Condition checked in the cycle after the trigger.
`define CIR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("collision impulse resolver check failed");
`else
`define CIR_ASSERT_IMP(lbl, ante, cons)
`define CIR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/cir_pkg.sv =====
// Shared constants and types of the collision impulse resolver.
package cir_pkg;
    localparam int MASS_W      = 16;
    localparam int BOUNCE_W    = 9;
    localparam int ELAST_W     = 10;
    localparam int UNIT_QB     = 15;
    localparam int UNIT_W      = 16;
    localparam int UNIT_SHIFT  = 24;
    localparam int WEIGHT_QB   = 16;

    localparam logic [MASS_W-1:0]   MASS_RESET   = 16'd256;
    localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 9'd0;
    localparam logic [BOUNCE_W-1:0] BOUNCE_ONE   = 9'd256;

    typedef enum logic [0:0] {
        CFG_OWN_MASS       = 1'b0,
        CFG_OWN_BOUNCINESS = 1'b1
    } cfg_index_t;
endpackage

// ===== design/cir_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband payload.
module cir_div_pipe #(
    parameter int NW  = 32,
    parameter int DW  = 17,
    parameter int QB  = 16,
    parameter int SBW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NW-1:0]  num,
    input  logic [DW-1:0]  den,
    input  logic [SBW-1:0] side_in,
    output logic           out_valid,
    output logic [QB-1:0]  quot,
    output logic [SBW-1:0] side_out
);
    // The quotient must fit in QB bits; the caller guarantees it.
    localparam int CMPW = ((NW > DW + QB - 1) ? NW : DW + QB - 1) + 1;

    logic            valid_reg [QB];
    logic [CMPW-1:0] rem_reg   [QB];
    logic [DW-1:0]   den_reg   [QB];
    logic [QB-1:0]   quot_reg  [QB];
    logic [SBW-1:0]  side_reg  [QB];

    logic            valid_next [QB];
    logic [CMPW-1:0] rem_next   [QB];
    logic [DW-1:0]   den_next   [QB];
    logic [QB-1:0]   quot_next  [QB];
    logic [SBW-1:0]  side_next  [QB];

    always_comb
    begin
        logic [CMPW-1:0] rem_in;
        logic [CMPW-1:0] trial;
        logic [QB-1:0]   q_in;
        logic            ge;
        for (int s = 0; s < QB; s++)
        begin
            if (s == 0)
            begin
                valid_next[s] = in_valid;
                rem_in        = CMPW'(num);
                den_next[s]   = den;
                q_in          = '0;
                side_next[s]  = side_in;
            end
            else
            begin
                valid_next[s] = valid_reg[s-1];
                rem_in        = rem_reg[s-1];
                den_next[s]   = den_reg[s-1];
                q_in          = quot_reg[s-1];
                side_next[s]  = side_reg[s-1];
            end
            trial        = CMPW'(den_next[s]) << (QB - 1 - s);
            ge           = (rem_in >= trial);
            rem_next[s]  = ge ? (rem_in - trial) : rem_in;
            quot_next[s] = {q_in[QB-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QB; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < QB; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QB; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_next[s];
                quot_reg[s] <= quot_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign quot      = quot_reg[QB-1];
    assign side_out  = side_reg[QB-1];
endmodule

// ===== design/cir_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, with a sideband payload.
module cir_sqrt_pipe #(
    parameter int RW  = 26,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] radicand,
    input  logic [SBW-1:0]  side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SBW-1:0]  side_out
);
    localparam int XW  = 2 * RW;
    localparam int RMW = RW + 4;

    logic           valid_reg [RW];
    logic [RMW-1:0] rem_reg   [RW];
    logic [RW-1:0]  root_reg  [RW];
    logic [XW-1:0]  x_reg     [RW];
    logic [SBW-1:0] side_reg  [RW];

    logic           valid_next [RW];
    logic [RMW-1:0] rem_next   [RW];
    logic [RW-1:0]  root_next  [RW];
    logic [XW-1:0]  x_next     [RW];
    logic [SBW-1:0] side_next  [RW];

    always_comb
    begin
        logic [RMW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [XW-1:0]  x_in;
        logic [RMW-1:0] cur;
        logic [RMW-1:0] trial;
        logic           ge;
        for (int s = 0; s < RW; s++)
        begin
            if (s == 0)
            begin
                valid_next[s] = in_valid;
                rem_in        = '0;
                root_in       = '0;
                x_in          = radicand;
                side_next[s]  = side_in;
            end
            else
            begin
                valid_next[s] = valid_reg[s-1];
                rem_in        = rem_reg[s-1];
                root_in       = root_reg[s-1];
                x_in          = x_reg[s-1];
                side_next[s]  = side_reg[s-1];
            end
            cur          = {rem_in[RW+1:0], x_in[XW-1:XW-2]};
            trial        = RMW'({root_in, 2'b01});
            ge           = (cur >= trial);
            rem_next[s]  = ge ? (cur - trial) : cur;
            root_next[s] = {root_in[RW-2:0], ge};
            x_next[s]    = x_in << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < RW; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < RW; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < RW; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                x_reg[s]    <= x_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];
endmodule

// ===== design/collision_impulse_resolver_unit.sv =====
// Throughput: one item per cycle while the skid slot is free; every stage is a register
// slice under one shared enable. The pipeline length comes mostly from the mass-weight
// divider (16 stages), the square root of the normal length (COMPONENT_WIDTH + 10 stages)
// and the three unit-normal dividers (15 stages).
// Reset (rst_n, asynchronous, active low) empties the pipeline and the output stage and
// sets own_mass to 1.0 and own_bounciness to 0.
module collision_impulse_resolver_unit
    import cir_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Contact items in.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata, low to high: velocity_vec, impulse_vec, normal_vec, other_mass,
    // other_velocity_vec, other_impulse_vec, other_bounciness, zero fill.
    input  logic [((15*COMPONENT_WIDTH+32)/8)*8-1:0] s_axis_tdata,
    // tuser: other_immovable.
    input  logic [0:0] s_axis_tuser,

    // Result items out.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata, low to high: result_impulse_vec, zero fill.
    output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser, low to high: resolved, degenerate_normal.
    output logic [1:0] m_axis_tuser
);
`include "collision_impulse_resolver_unit_defines.svh"

    localparam int CW   = COMPONENT_WIDTH;
    localparam int VW   = 3 * CW;
    localparam int RDW  = CW + 2;            // relative velocity component
    localparam int QW   = 2 * CW;            // squared normal length
    localparam int RW   = CW + 10;           // root of Q scaled by 2^20
    localparam int DNW  = CW + UNIT_SHIFT;   // unit-normal dividend
    localparam int PDW  = RDW + UNIT_W;      // r times u
    localparam int DDW  = CW + 20;           // dot product
    localparam int GW   = CW + 15;           // impulse magnitude
    localparam int APW  = GW + UNIT_QB;      // magnitude times unit component
    localparam int SVW  = CW + 10;           // signed sum before saturation
    localparam int ODW  = ((3*CW+7)/8)*8;

    localparam int OFF_VEL = 0;
    localparam int OFF_IMP = VW;
    localparam int OFF_NRM = 2 * VW;
    localparam int OFF_OM  = 3 * VW;
    localparam int OFF_OV  = 3 * VW + MASS_W;
    localparam int OFF_OI  = 4 * VW + MASS_W;
    localparam int OFF_OB  = 5 * VW + MASS_W;

    // Global pipeline enable: the pipeline moves while the skid slot is free.
    logic en;

    //------------------------------------------------------------------
    // Configuration registers.
    //------------------------------------------------------------------
    logic [MASS_W-1:0]   own_mass_reg;
    logic [BOUNCE_W-1:0] own_bounce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mass_reg   <= MASS_RESET;
            own_bounce_reg <= BOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OWN_MASS:       own_mass_reg   <= cfg_data[MASS_W-1:0];
                CFG_OWN_BOUNCINESS: own_bounce_reg <= cfg_data[BOUNCE_W-1:0];
                default:            own_mass_reg   <= own_mass_reg;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Stage 0: unpack the item, form the relative velocity, the combined
    // elasticity 1 + e and the operands of the mass weight.
    //------------------------------------------------------------------
    logic [VW-1:0]      n0_flat;
    logic [3*RDW-1:0]   r0_flat;
    logic [ELAST_W-1:0] elast0;
    logic [31:0]        wnum0;
    logic [MASS_W:0]    wden0;

    always_comb
    begin
        logic signed [RDW-1:0]    rv;
        logic [BOUNCE_W+1:0]      esum;
        logic [MASS_W-1:0]        m1;
        logic [MASS_W-1:0]        m2;
        logic                     imm;
        imm     = s_axis_tuser[0];
        n0_flat = s_axis_tdata[OFF_NRM +: VW];
        for (int k = 0; k < 3; k++)
        begin
            rv = RDW'($signed(s_axis_tdata[OFF_VEL + k*CW +: CW]))
               + RDW'($signed(s_axis_tdata[OFF_IMP + k*CW +: CW]));
            if (!imm)
            begin
                rv = rv - RDW'($signed(s_axis_tdata[OFF_OV + k*CW +: CW]))
                        - RDW'($signed(s_axis_tdata[OFF_OI + k*CW +: CW]));
            end
            r0_flat[k*RDW +: RDW] = rv;
        end
        esum = (BOUNCE_W+2)'(own_bounce_reg);
        if (!imm)
        begin
            esum = esum + (BOUNCE_W+2)'(s_axis_tdata[OFF_OB +: BOUNCE_W]);
        end
        if (esum > (BOUNCE_W+2)'(BOUNCE_ONE))
        begin
            esum = (BOUNCE_W+2)'(BOUNCE_ONE);
        end
        elast0 = ELAST_W'(esum) + ELAST_W'(BOUNCE_ONE);
        // A zero mass counts as one LSB.
        m1 = (own_mass_reg == '0) ? MASS_W'(1) : own_mass_reg;
        m2 = (s_axis_tdata[OFF_OM +: MASS_W] == '0) ? MASS_W'(1)
                                                   : s_axis_tdata[OFF_OM +: MASS_W];
        wnum0 = {m2, 16'd0};
        wden0 = (MASS_W+1)'(m1) + (MASS_W+1)'(m2);
    end

    localparam int SB0W = 1 + ELAST_W + VW + 3*RDW + VW;

    logic              s0_valid_reg;
    logic [SB0W-1:0]   s0_side_reg;
    logic [31:0]       s0_wnum_reg;
    logic [MASS_W:0]   s0_wden_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side_reg <= {s_axis_tuser[0], elast0,
                            s_axis_tdata[OFF_IMP +: VW], r0_flat, n0_flat};
            s0_wnum_reg <= wnum0;
            s0_wden_reg <= wden0;
        end
    end

    //------------------------------------------------------------------
    // Mass weight w = m2 * 2^16 / (m1 + m2).
    //------------------------------------------------------------------
    logic                 wd_valid;
    logic [WEIGHT_QB-1:0] wd_quot;
    logic [SB0W-1:0]      wd_side;

    cir_div_pipe #(
        .NW  (32),
        .DW  (MASS_W + 1),
        .QB  (WEIGHT_QB),
        .SBW (SB0W)
    ) u_weight_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .num       (s0_wnum_reg),
        .den       (s0_wden_reg),
        .side_in   (s0_side_reg),
        .out_valid (wd_valid),
        .quot      (wd_quot),
        .side_out  (wd_side)
    );

    //------------------------------------------------------------------
    // Stages 1 and 2: squares of the normal components, then their sum.
    //------------------------------------------------------------------
    localparam int SB1W = WEIGHT_QB + SB0W;

    logic            s1_valid_reg;
    logic [QW-1:0]   s1_sq_reg [3];
    logic [SB1W-1:0] s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= wd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_sq_reg[k] <= QW'($signed(wd_side[k*CW +: CW])
                                    * $signed(wd_side[k*CW +: CW]));
            end
            s1_side_reg <= {wd_quot, wd_side};
        end
    end

    localparam int SB2W = 1 + SB1W;

    logic            s2_valid_reg;
    logic [QW-1:0]   s2_q_reg;
    logic [SB2W-1:0] s2_side_reg;
    logic [QW+1:0]   q_sum;

    assign q_sum = (QW+2)'(s1_sq_reg[0]) + (QW+2)'(s1_sq_reg[1]) + (QW+2)'(s1_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_q_reg    <= q_sum[QW-1:0];
            s2_side_reg <= {(q_sum == '0), s1_side_reg};
        end
    end

    //------------------------------------------------------------------
    // Normal length L = floor(sqrt(Q * 2^20)).
    //------------------------------------------------------------------
    logic            sq_valid;
    logic [RW-1:0]   sq_root;
    logic [SB2W-1:0] sq_side;

    cir_sqrt_pipe #(
        .RW  (RW),
        .SBW (SB2W)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .radicand  ({s2_q_reg, 20'd0}),
        .side_in   (s2_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    //------------------------------------------------------------------
    // Unit normal u_k = n_k * 2^24 / L, truncated toward zero. The
    // magnitudes divide; the sign rides along in the sideband.
    //------------------------------------------------------------------
    localparam int SBDW = 1 + SB2W - VW;   // drops n, adds the sign of n_x

    logic [DNW-1:0] dnum [3];

    always_comb
    begin
        logic [CW-1:0] nk;
        for (int k = 0; k < 3; k++)
        begin
            nk      = sq_side[k*CW +: CW];
            dnum[k] = {(nk[CW-1] ? (~nk + CW'(1)) : nk), UNIT_SHIFT'(0)};
        end
    end

    logic               dv_valid;
    logic               dv_valid_y;
    logic               dv_valid_z;
    logic [UNIT_QB-1:0] dv_quot [3];
    logic [SBDW-1:0]    dv_side;
    logic               dv_sign1;
    logic               dv_sign2;

    cir_div_pipe #(
        .NW  (DNW),
        .DW  (RW),
        .QB  (UNIT_QB),
        .SBW (SBDW)
    ) u_unit_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (dnum[0]),
        .den       (sq_root),
        .side_in   ({sq_side[SB2W-1:VW], sq_side[CW-1]}),
        .out_valid (dv_valid),
        .quot      (dv_quot[0]),
        .side_out  (dv_side)
    );

    cir_div_pipe #(
        .NW  (DNW),
        .DW  (RW),
        .QB  (UNIT_QB),
        .SBW (1)
    ) u_unit_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (dnum[1]),
        .den       (sq_root),
        .side_in   (sq_side[2*CW-1]),
        .out_valid (dv_valid_y),
        .quot      (dv_quot[1]),
        .side_out  (dv_sign1)
    );

    cir_div_pipe #(
        .NW  (DNW),
        .DW  (RW),
        .QB  (UNIT_QB),
        .SBW (1)
    ) u_unit_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (dnum[2]),
        .den       (sq_root),
        .side_in   (sq_side[3*CW-1]),
        .out_valid (dv_valid_z),
        .quot      (dv_quot[2]),
        .side_out  (dv_sign2)
    );

    // Sideband after the dividers, low to high: sign of n_x, r, ik, elasticity,
    // immovable, weight, zero normal.
    localparam int SD_R    = 1;
    localparam int SD_IK   = SD_R + 3*RDW;
    localparam int SD_EL   = SD_IK + VW;
    localparam int SD_IMM  = SD_EL + ELAST_W;
    localparam int SD_W    = SD_IMM + 1;
    localparam int SD_ZERO = SD_W + WEIGHT_QB;

    logic signed [UNIT_W-1:0] u_c [3];

    always_comb
    begin
        logic sgn;
        for (int k = 0; k < 3; k++)
        begin
            sgn = (k == 0) ? dv_side[0] : ((k == 1) ? dv_sign1 : dv_sign2);
            u_c[k] = sgn ? -$signed({1'b0, dv_quot[k]}) : $signed({1'b0, dv_quot[k]});
        end
    end

    //------------------------------------------------------------------
    // Back end stage 1: products r_k * u_k.
    //------------------------------------------------------------------
    logic                     b1_valid_reg;
    logic signed [PDW-1:0]    b1_prod_reg [3];
    logic signed [UNIT_W-1:0] b1_u_reg [3];
    logic [VW-1:0]            b1_ik_reg;
    logic [ELAST_W-1:0]       b1_elast_reg;
    logic                     b1_imm_reg;
    logic [WEIGHT_QB-1:0]     b1_w_reg;
    logic                     b1_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                b1_prod_reg[k] <= $signed(dv_side[SD_R + k*RDW +: RDW]) * u_c[k];
                b1_u_reg[k]    <= u_c[k];
            end
            b1_ik_reg    <= dv_side[SD_IK +: VW];
            b1_elast_reg <= dv_side[SD_EL +: ELAST_W];
            b1_imm_reg   <= dv_side[SD_IMM];
            b1_w_reg     <= dv_side[SD_W +: WEIGHT_QB];
            b1_zero_reg  <= dv_side[SD_ZERO];
        end
    end

    //------------------------------------------------------------------
    // Back end stage 2: dot product D, approach test and -D.
    //------------------------------------------------------------------
    logic signed [DDW-1:0] dot;

    assign dot = DDW'(b1_prod_reg[0]) + DDW'(b1_prod_reg[1]) + DDW'(b1_prod_reg[2]);

    logic                     b2_valid_reg;
    logic [DDW-1:0]           b2_negd_reg;
    logic                     b2_approach_reg;
    logic signed [UNIT_W-1:0] b2_u_reg [3];
    logic [VW-1:0]            b2_ik_reg;
    logic [ELAST_W-1:0]       b2_elast_reg;
    logic                     b2_imm_reg;
    logic [WEIGHT_QB-1:0]     b2_w_reg;
    logic                     b2_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_negd_reg     <= -dot;
            b2_approach_reg <= dot[DDW-1];
            b2_u_reg        <= b1_u_reg;
            b2_ik_reg       <= b1_ik_reg;
            b2_elast_reg    <= b1_elast_reg;
            b2_imm_reg      <= b1_imm_reg;
            b2_w_reg        <= b1_w_reg;
            b2_zero_reg     <= b1_zero_reg;
        end
    end

    //------------------------------------------------------------------
    // Back end stage 3: g = (-D * (1 + e) + 2^13) >> 14.
    //------------------------------------------------------------------
    logic [DDW+ELAST_W-1:0] g_full;

    assign g_full = (DDW+ELAST_W)'(b2_negd_reg) * (DDW+ELAST_W)'(b2_elast_reg)
                  + (DDW+ELAST_W)'(1 << 13);

    logic                     b3_valid_reg;
    logic [GW-1:0]            b3_g_reg;
    logic                     b3_approach_reg;
    logic signed [UNIT_W-1:0] b3_u_reg [3];
    logic [VW-1:0]            b3_ik_reg;
    logic                     b3_imm_reg;
    logic [WEIGHT_QB-1:0]     b3_w_reg;
    logic                     b3_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_g_reg        <= g_full[GW+13:14];
            b3_approach_reg <= b2_approach_reg;
            b3_u_reg        <= b2_u_reg;
            b3_ik_reg       <= b2_ik_reg;
            b3_imm_reg      <= b2_imm_reg;
            b3_w_reg        <= b2_w_reg;
            b3_zero_reg     <= b2_zero_reg;
        end
    end

    //------------------------------------------------------------------
    // Back end stage 4: scale by the mass weight against a movable body.
    //------------------------------------------------------------------
    logic [GW+WEIGHT_QB:0] gw_full;

    assign gw_full = (GW+WEIGHT_QB+1)'(b3_g_reg) * (GW+WEIGHT_QB+1)'(b3_w_reg)
                   + (GW+WEIGHT_QB+1)'(1 << 15);

    logic                     b4_valid_reg;
    logic [GW-1:0]            b4_g_reg;
    logic                     b4_approach_reg;
    logic signed [UNIT_W-1:0] b4_u_reg [3];
    logic [VW-1:0]            b4_ik_reg;
    logic                     b4_imm_reg;
    logic                     b4_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4_g_reg        <= b3_imm_reg ? b3_g_reg : gw_full[GW+15:16];
            b4_approach_reg <= b3_approach_reg;
            b4_u_reg        <= b3_u_reg;
            b4_ik_reg       <= b3_ik_reg;
            b4_imm_reg      <= b3_imm_reg;
            b4_zero_reg     <= b3_zero_reg;
        end
    end

    //------------------------------------------------------------------
    // Back end stage 5: g times each unit-normal magnitude.
    //------------------------------------------------------------------
    logic               b5_valid_reg;
    logic [APW-1:0]     b5_prod_reg [3];
    logic [2:0]         b5_neg_reg;
    logic               b5_approach_reg;
    logic [VW-1:0]      b5_ik_reg;
    logic               b5_imm_reg;
    logic               b5_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                b5_prod_reg[k] <= APW'(b4_g_reg)
                                * APW'(b4_u_reg[k][UNIT_W-1] ? -b4_u_reg[k] : b4_u_reg[k]);
                b5_neg_reg[k]  <= b4_u_reg[k][UNIT_W-1];
            end
            b5_approach_reg <= b4_approach_reg;
            b5_ik_reg       <= b4_ik_reg;
            b5_imm_reg      <= b4_imm_reg;
            b5_zero_reg     <= b4_zero_reg;
        end
    end

    // Valid bits of the back end travel together under the shared enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= dv_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
        end
    end

    //------------------------------------------------------------------
    // Result: round half away from zero, add to the pending impulse for a
    // movable body, saturate each component. A zero normal or a contact
    // that is not approaching passes the pending impulse through.
    //------------------------------------------------------------------
    logic          res_resolved;
    logic [VW-1:0] res_vec;

    assign res_resolved = !b5_zero_reg && b5_approach_reg;

    always_comb
    begin
        logic [APW-1:0]        rnd;
        logic signed [SVW-1:0] adj;
        logic signed [SVW-1:0] val;
        for (int k = 0; k < 3; k++)
        begin
            rnd = b5_prod_reg[k] + APW'(1 << 21);
            adj = SVW'(rnd[APW-1:22]);
            if (b5_neg_reg[k])
            begin
                adj = -adj;
            end
            val = b5_imm_reg ? adj : (adj + SVW'($signed(b5_ik_reg[k*CW +: CW])));
            if (val[SVW-1:CW-1] == '0 || val[SVW-1:CW-1] == '1)
            begin
                res_vec[k*CW +: CW] = val[CW-1:0];
            end
            else
            begin
                res_vec[k*CW +: CW] = {val[SVW-1], {(CW-1){~val[SVW-1]}}};
            end
        end
        if (!res_resolved)
        begin
            res_vec = b5_ik_reg;
        end
    end

    //------------------------------------------------------------------
    // Output register with a one-item skid slot. The pipeline only stops
    // once the skid slot holds an item, so the enable comes from a flop.
    //------------------------------------------------------------------
    logic          out_valid_reg;
    logic [VW-1:0] out_vec_reg;
    logic          out_resolved_reg;
    logic          out_degen_reg;
    logic          skid_valid_reg;
    logic [VW-1:0] skid_vec_reg;
    logic          skid_resolved_reg;
    logic          skid_degen_reg;
    logic          take;
    logic          push;

    assign en   = !skid_valid_reg;
    assign take = out_valid_reg && m_axis_tready;
    assign push = en && b5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !take)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (take)
            begin
                out_vec_reg      <= skid_vec_reg;
                out_resolved_reg <= skid_resolved_reg;
                out_degen_reg    <= skid_degen_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_vec_reg      <= res_vec;
                skid_resolved_reg <= res_resolved;
                skid_degen_reg    <= b5_zero_reg;
            end
            else
            begin
                out_vec_reg      <= res_vec;
                out_resolved_reg <= res_resolved;
                out_degen_reg    <= b5_zero_reg;
            end
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ODW'(out_vec_reg);
    assign m_axis_tuser  = {out_degen_reg, out_resolved_reg};

    // The skid slot only ever fills behind an occupied output register.
    `CIR_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A finished item that meets a stalled output lands in the skid slot.
    `CIR_ASSERT_NXT(a_skid_catches, out_valid_reg && !m_axis_tready && push, skid_valid_reg)
    // A result is never both recomputed and flagged as a zero normal.
    `CIR_ASSERT_IMP(a_flags_exclusive, out_valid_reg, !(out_resolved_reg && out_degen_reg))
    // The three unit-normal dividers move in lockstep.
    `CIR_ASSERT_IMP(a_unit_div_lockstep, 1'b1, dv_valid_y == dv_valid && dv_valid_z == dv_valid)
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the collision impulse resolver unit.
`timescale 1ns / 100ps

module tb;
    import cir_pkg::*;

    localparam int CW       = 16;
    localparam int VEC_W    = 3 * CW;
    localparam int S_DATA_W = ((15 * CW + 32) / 8) * 8;
    localparam int M_DATA_W = ((3 * CW + 7) / 8) * 8;
    // The pipeline is CW + 50 deep; allow some extra before a register write.
    localparam int DRAIN_CYCLES = CW + 50 + 20;

    // One contact as it enters the block.
    typedef struct packed {
        logic [8:0]       other_bounce;
        logic [VEC_W-1:0] other_impulse;
        logic [VEC_W-1:0] other_velocity;
        logic [15:0]      other_mass;
        logic [VEC_W-1:0] normal;
        logic [VEC_W-1:0] impulse;
        logic [VEC_W-1:0] velocity;
        logic             immovable;
    } contact_t;

    // One resolved impulse as it leaves the block.
    typedef struct packed {
        logic [VEC_W-1:0] impulse;
        logic             resolved;
        logic             degenerate;
    } impulse_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                cfg_we = 1'b0;
    cfg_index_t          cfg_index = CFG_OWN_MASS;
    logic [15:0]         cfg_data = '0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;

    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    // Local copy of the two configuration registers.
    logic [15:0] mass_reg = MASS_RESET;
    logic [8:0]  bounce_reg = BOUNCE_RESET;

    impulse_result_t expected_impulses[$];

    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  resolved_seen = 0;
    int  degenerate_seen = 0;
    bit  idling_on = 1'b1;
    int  ready_stall = 0;

    always #5 clk = ~clk;

    collision_impulse_resolver_unit #(
        .COMPONENT_WIDTH(CW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Signed component k of a packed vector.
    function automatic longint lane(logic [VEC_W-1:0] v, int k);
        logic signed [CW-1:0] c;
        c = v[k*CW +: CW];
        return longint'(c);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Computes the impulse the block should produce for one contact,
    // using the current register copies.
    function automatic impulse_result_t resolve_contact(contact_t c);
        impulse_result_t res;
        longint n[3], r[3], u[3], own_imp[3];
        longint unsigned sq_len, len, elast, g, m1, m2, w, mag;
        longint closing, adj, val;
        logic [VEC_W-1:0] packed_vec;
        sq_len = 0;
        closing = 0;
        packed_vec = '0;
        for (int k = 0; k < 3; k++)
        begin
            n[k] = lane(c.normal, k);
            own_imp[k] = lane(c.impulse, k);
            r[k] = lane(c.velocity, k) + own_imp[k];
            if (!c.immovable)
                r[k] = r[k] - (lane(c.other_velocity, k) + lane(c.other_impulse, k));
            sq_len = sq_len + longint'(n[k] * n[k]);
        end
        res.impulse = c.impulse;
        res.resolved = 1'b0;
        res.degenerate = 1'b0;
        if (sq_len == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        len = int_sqrt(sq_len << 20);
        for (int k = 0; k < 3; k++)
        begin
            u[k] = (n[k] * (longint'(1) << 24)) / longint'(len);
            closing = closing + r[k] * u[k];
        end
        // Separating or sliding contacts keep their pending impulse.
        if (closing >= 0)
            return res;
        elast = bounce_reg;
        if (!c.immovable)
            elast = elast + c.other_bounce;
        if (elast > 256)
            elast = 256;
        g = (longint'(-closing) * (256 + elast) + (64'd1 << 13)) >> 14;
        if (!c.immovable)
        begin
            m1 = (mass_reg == 0) ? 1 : mass_reg;
            m2 = (c.other_mass == 0) ? 1 : c.other_mass;
            w = (m2 << 16) / (m1 + m2);
            g = (g * w + (64'd1 << 15)) >> 16;
        end
        for (int k = 0; k < 3; k++)
        begin
            mag = (u[k] < 0) ? longint'(-u[k]) : longint'(u[k]);
            adj = longint'((g * mag + (64'd1 << 21)) >> 22);
            if (u[k] < 0)
                adj = -adj;
            val = c.immovable ? adj : own_imp[k] + adj;
            if (val > 32767)
                val = 32767;
            if (val < -32768)
                val = -32768;
            packed_vec[k*CW +: CW] = val[CW-1:0];
        end
        res.impulse = packed_vec;
        res.resolved = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Result side: random stalls on tready and a check of every item taken.
    always @(posedge clk)
    begin
        impulse_result_t want;
        int next_stall;
        next_stall = ready_stall;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_impulses.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata, 0);
            else
            begin
                want = expected_impulses.pop_front();
                if (m_axis_tdata[VEC_W-1:0] !== want.impulse)
                    report_mismatch("result_impulse_vec", m_axis_tdata[VEC_W-1:0], want.impulse);
                if (m_axis_tuser[0] !== want.resolved)
                    report_mismatch("resolved", m_axis_tuser[0], want.resolved);
                if (m_axis_tuser[1] !== want.degenerate)
                    report_mismatch("degenerate_normal", m_axis_tuser[1], want.degenerate);
                resolved_seen += want.resolved;
                degenerate_seen += want.degenerate;
            end
            next_stall = idling_on ? $urandom_range(0, 11) : 0;
        end
        if (next_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall <= next_stall - 1;
        end
        else
        begin
            m_axis_tready <= rst_n;
            ready_stall <= 0;
        end
    end

    // Sends one contact, records its expected result when it is taken, and
    // then, while idling is on, idles for a random number of cycles.
    task automatic send_contact(contact_t c);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, c.other_bounce, c.other_impulse, c.other_velocity,
                         c.other_mass, c.normal, c.impulse, c.velocity};
        s_axis_tuser <= c.immovable;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_impulses.push_back(resolve_contact(c));
        items_sent++;
        gap = idling_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for the pipeline to drain before the registers may change.
    task automatic wait_drained();
        stop_sending();
        while (expected_impulses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The enable drops for one cycle so that two writes never meet in one edge.
    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OWN_MASS)
            mass_reg = value;
        else
            bounce_reg = value[8:0];
        @(posedge clk);
    endtask

    // One component: mostly moderate values, sometimes full range, a rail or zero.
    function automatic logic [CW-1:0] rand_component();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return CW'($urandom_range(0, 4096) - 2048);
        else if (sel < 8)
            return CW'($urandom);
        else if (sel == 8)
            return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        else
            return '0;
    endfunction

    function automatic logic [VEC_W-1:0] rand_vector();
        return {rand_component(), rand_component(), rand_component()};
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        c.velocity = rand_vector();
        c.impulse = rand_vector();
        c.normal = ($urandom_range(0, 19) == 0) ? '0 : rand_vector();
        c.immovable = $urandom_range(0, 2) == 0;
        c.other_mass = ($urandom_range(0, 9) == 0) ? 16'(($urandom_range(0, 1)) ? 0 : 16'hffff)
                                                   : 16'($urandom);
        c.other_velocity = rand_vector();
        c.other_impulse = rand_vector();
        c.other_bounce = 9'($urandom);
        return c;
    endfunction

    function automatic logic [VEC_W-1:0] vec3(logic [CW-1:0] x, logic [CW-1:0] y,
                                              logic [CW-1:0] z);
        return {z, y, x};
    endfunction

    // Hand-picked contacts covering each behavior of the block.
    task automatic test_directed();
        contact_t c;
        c = '0;
        // Degenerate normal, both contact kinds.
        c.impulse = vec3(16'h0123, 16'hfedc, 16'h7fff);
        c.velocity = vec3(16'h8000, 0, 0);
        send_contact(c);
        c.immovable = 1'b1;
        send_contact(c);
        // Obstacle with a +x normal, moving along -x and then +x; with the pending impulse both separate.
        c.normal = vec3(16'h0100, 0, 0);
        c.velocity = vec3(16'hff00, 0, 0);
        send_contact(c);
        c.velocity = vec3(16'h0100, 0, 0);
        send_contact(c);
        // Obstacle at the rails: big closing speed saturates the result; the other two normals do not approach.
        c.velocity = vec3(16'h8000, 16'h8000, 16'h8000);
        c.impulse = vec3(16'h8000, 16'h8000, 16'h8000);
        c.normal = vec3(16'h7fff, 16'h7fff, 16'h7fff);
        send_contact(c);
        c.normal = vec3(16'h8000, 16'h8000, 16'h8000);
        send_contact(c);
        c.normal = vec3(16'h0001, 0, 16'hffff);
        send_contact(c);
        // Two bodies, approaching and not, with bounciness sums at, above and below one.
        c.immovable = 1'b0;
        c.velocity = vec3(16'hfe00, 16'h0040, 0);
        c.impulse = vec3(16'h7f00, 16'h8100, 16'h0010);
        c.normal = vec3(16'h0300, 16'h0400, 0);
        c.other_velocity = vec3(16'h0200, 0, 0);
        c.other_impulse = '0;
        c.other_mass = 16'h0100;
        c.other_bounce = 9'd256;
        send_contact(c);
        c.other_bounce = 9'h1ff;
        c.other_mass = 16'h0000;
        send_contact(c);
        c.other_mass = 16'hffff;
        c.other_bounce = 9'd0;
        send_contact(c);
        c.other_velocity = vec3(16'h8000, 0, 0);
        send_contact(c);
        c.other_velocity = vec3(16'h7fff, 16'h7fff, 16'h7fff);
        c.other_impulse = vec3(16'h7fff, 16'h7fff, 16'h7fff);
        c.velocity = vec3(16'h8000, 16'h8000, 16'h8000);
        c.impulse = vec3(16'h7fff, 16'h8000, 16'h7fff);
        c.normal = vec3(16'hffff, 16'hffff, 16'hffff);
        send_contact(c);
        c.normal = vec3(16'h0001, 16'h0001, 16'h0001);
        send_contact(c);
        // Obstacle ignores every field of the other body.
        c.immovable = 1'b1;
        c.other_bounce = 9'h1ff;
        c.other_mass = '0;
        send_contact(c);
        wait_drained();
    endtask

    // Walks the registers through their extremes, a few contacts each.
    task automatic test_register_settings();
        logic [15:0] masses[5] = '{16'h0000, 16'h0001, 16'hffff, 16'h0100, 16'h8000};
        logic [15:0] bounces[5] = '{16'h0000, 16'h0100, 16'h01ff, 16'hfe80, 16'h0080};
        for (int s = 0; s < 5; s++)
        begin
            write_register(CFG_OWN_MASS, masses[s]);
            write_register(CFG_OWN_BOUNCINESS, bounces[s]);
            for (int i = 0; i < 40; i++)
                send_contact(rand_contact());
            wait_drained();
        end
    endtask

    // Bulk random contacts in phases with fresh register values; one phase
    // runs without any idling on either side.
    task automatic test_random_contacts();
        for (int phase = 0; phase < 8; phase++)
        begin
            idling_on = (phase != 3);
            write_register(CFG_OWN_MASS, 16'($urandom));
            write_register(CFG_OWN_BOUNCINESS, 16'($urandom_range(0, 300)));
            for (int i = 0; i < 190; i++)
                send_contact(rand_contact());
            wait_drained();
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_settings();
        test_random_contacts();
        $display("Sent %0d contacts and checked %0d results across several register settings.",
                 items_sent, results_seen);
        $display("%0d results resolved an approach, %0d had a zero normal.",
                 resolved_seen, degenerate_seen);
        if (error_count == 0 && expected_impulses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Timeout after %0t", $realtime);
        $display("Verification failed");
        $finish;
    end
endmodule

// ===== collision_impulse_resolver_unit.f =====
+incdir+design
design/cir_pkg.sv
design/cir_div_pipe.sv
design/cir_sqrt_pipe.sv
design/collision_impulse_resolver_unit.sv
verif/tb.sv
